/* rtl/tgr_pkg.sv */
// tgr_pkg: shared types, codes and constants of the touchpad gesture recognizer
// depends on nothing; used by every other rtl file
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

	localparam int COORD_W  = 16;
	localparam int TIME_W   = 32;
	localparam int VALUE_W  = 17;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIST_W   = 15;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MS       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_DISTANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP_MS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_EXPIRE_MS    = 2'd3;

	// configuration reset values
	localparam logic [15:0]       TAP_MAX_MS_RST       = 16'd200;
	localparam logic [DIST_W-1:0] TAP_MAX_DISTANCE_RST = 15'd50;
	localparam logic [15:0]       DOUBLE_TAP_MS_RST    = 16'd400;
	localparam logic [15:0]       TAP_EXPIRE_MS_RST    = 16'd600;

	typedef enum logic {
		FUNC_FRAME = 1'b0,
		FUNC_TIMER = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		EV_RELX   = 3'd0,
		EV_RELY   = 3'd1,
		EV_WHEEL  = 3'd2,
		EV_HWHEEL = 3'd3,
		EV_LEFT   = 3'd4,
		EV_RIGHT  = 3'd5
	} event_kind_t;

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_LEFT  = 2'd1;
	localparam logic [1:0] PEND_RIGHT = 2'd2;

	typedef struct packed {
		logic               func;
		logic [1:0]         touches;
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic [TIME_W-1:0]  now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]                event_kind;
		logic signed [VALUE_W-1:0] event_value;
		logic                      arm_release;
		logic                      last;
	} res_t;

	// up to two results produced by one item
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic [15:0]       tap_max_ms;
		logic [DIST_W-1:0] tap_max_distance;
		logic [15:0]       double_tap_ms;
		logic [15:0]       tap_expire_ms;
	} cfg_t;

	// wrapped 16 bit difference, sign extended to the result width
	function automatic logic signed [VALUE_W-1:0] delta17(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		logic [COORD_W-1:0] d;
		d = a - b;
		return {d[COORD_W-1], d};
	endfunction

	function automatic logic [COORD_W-1:0] absdiff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic res_t mk_res(
		input event_kind_t kind,
		input logic signed [VALUE_W-1:0] value,
		input logic arm
	);
		res_t r;
		r.event_kind  = kind;
		r.event_value = value;
		r.arm_release = arm;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/tgr_if.sv */
// tgr_in_if / tgr_out_if: valid/ready channels for input items and result beats
// depends on tgr_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tgr_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [1:0]                  touches;
	logic [tgr_pkg::COORD_W-1:0] first_x;
	logic [tgr_pkg::COORD_W-1:0] first_y;
	logic [tgr_pkg::COORD_W-1:0] second_x;
	logic [tgr_pkg::COORD_W-1:0] second_y;
	logic [tgr_pkg::TIME_W-1:0]  now_ms;

	modport source(output valid, func, touches, first_x, first_y, second_x, second_y,
		now_ms, input ready);
	modport sink(input valid, func, touches, first_x, first_y, second_x, second_y,
		now_ms, output ready);
endinterface

interface tgr_out_if;
	logic                               valid;
	logic                               ready;
	logic [2:0]                         event_kind;
	logic signed [tgr_pkg::VALUE_W-1:0] event_value;
	logic                               arm_release;
	logic                               last;

	modport source(output valid, event_kind, event_value, arm_release, last, input ready);
	modport sink(input valid, event_kind, event_value, arm_release, last, output ready);
endinterface

`default_nettype wire

/* rtl/tgr_core.sv */
// tgr_core: gesture state, configuration registers and per-item result logic
// depends on tgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgr_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire tgr_pkg::item_t                 item,
	input  wire logic                           cfg_we,
	input  wire logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tgr_pkg::CFG_W-1:0]      cfg_data,
	output tgr_pkg::push_t                      push
);

	tgr_pkg::cfg_t cfg_q;

	logic [tgr_pkg::COORD_W-1:0] prev_fx_q, prev_fy_q, prev_sx_q, prev_sy_q;
	logic [tgr_pkg::COORD_W-1:0] start_x_q, start_y_q;
	logic [tgr_pkg::TIME_W-1:0]  touch_start_q, last_tap_q;
	logic one_valid_q, two_valid_q, tap_seen_q, drag_hold_q, left_held_q;
	logic [1:0] pending_q;

	logic [tgr_pkg::COORD_W-1:0] prev_fx_d, prev_fy_d, prev_sx_d, prev_sy_d;
	logic [tgr_pkg::COORD_W-1:0] start_x_d, start_y_d;
	logic [tgr_pkg::TIME_W-1:0]  touch_start_d, last_tap_d;
	logic one_valid_d, two_valid_d, tap_seen_d, drag_hold_d, left_held_d;
	logic [1:0] pending_d;

	logic [1:0]                          n;
	tgr_pkg::res_t                       r0, r1;
	logic [tgr_pkg::COORD_W:0]           sum_y, sum_py, sum_x, sum_px;
	logic signed [tgr_pkg::VALUE_W-1:0]  ym, xm;
	logic [tgr_pkg::TIME_W-1:0]          dur, gap;
	logic [tgr_pkg::COORD_W:0]           travel;
	logic                                is_tap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_max_ms       <= tgr_pkg::TAP_MAX_MS_RST;
			cfg_q.tap_max_distance <= tgr_pkg::TAP_MAX_DISTANCE_RST;
			cfg_q.double_tap_ms    <= tgr_pkg::DOUBLE_TAP_MS_RST;
			cfg_q.tap_expire_ms    <= tgr_pkg::TAP_EXPIRE_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgr_pkg::CFG_TAP_MAX_MS:       cfg_q.tap_max_ms <= cfg_data;
				tgr_pkg::CFG_TAP_MAX_DISTANCE: cfg_q.tap_max_distance <= cfg_data[tgr_pkg::DIST_W-1:0];
				tgr_pkg::CFG_DOUBLE_TAP_MS:    cfg_q.double_tap_ms <= cfg_data;
				tgr_pkg::CFG_TAP_EXPIRE_MS:    cfg_q.tap_expire_ms <= cfg_data;
			endcase
		end
	end

	// averaged two-finger positions and lift measurements
	always_comb begin
		sum_y  = {1'b0, item.first_y} + {1'b0, item.second_y};
		sum_py = {1'b0, prev_fy_q} + {1'b0, prev_sy_q};
		sum_x  = {1'b0, item.first_x} + {1'b0, item.second_x};
		sum_px = {1'b0, prev_fx_q} + {1'b0, prev_sx_q};
		ym     = tgr_pkg::delta17(sum_y[tgr_pkg::COORD_W:1], sum_py[tgr_pkg::COORD_W:1]);
		xm     = tgr_pkg::delta17(sum_x[tgr_pkg::COORD_W:1], sum_px[tgr_pkg::COORD_W:1]);
		dur    = item.now_ms - touch_start_q;
		gap    = item.now_ms - last_tap_q;
		travel = {1'b0, tgr_pkg::absdiff(prev_fx_q, start_x_q)}
			+ {1'b0, tgr_pkg::absdiff(prev_fy_q, start_y_q)};
		is_tap = (dur < {16'd0, cfg_q.tap_max_ms})
			&& (travel < {2'd0, cfg_q.tap_max_distance});
	end

	always_comb begin
		prev_fx_d = prev_fx_q; prev_fy_d = prev_fy_q;
		prev_sx_d = prev_sx_q; prev_sy_d = prev_sy_q;
		start_x_d = start_x_q; start_y_d = start_y_q;
		touch_start_d = touch_start_q; last_tap_d = last_tap_q;
		one_valid_d = one_valid_q; two_valid_d = two_valid_q;
		tap_seen_d = tap_seen_q; drag_hold_d = drag_hold_q; left_held_d = left_held_q;
		pending_d = pending_q;
		n  = 2'd0;
		r0 = '0;
		r1 = '0;

		if (item.func == tgr_pkg::FUNC_TIMER) begin
			if (pending_q == tgr_pkg::PEND_LEFT) begin
				r0 = tgr_pkg::mk_res(tgr_pkg::EV_LEFT, 17'sd0, 1'b0);
				n  = 2'd1;
			end else if (pending_q == tgr_pkg::PEND_RIGHT) begin
				r0 = tgr_pkg::mk_res(tgr_pkg::EV_RIGHT, 17'sd0, 1'b0);
				n  = 2'd1;
			end
			pending_d = tgr_pkg::PEND_NONE;
		end else if (item.touches == 2'd1) begin
			if (!one_valid_q || two_valid_q) begin
				// fresh touch, or drop from two fingers to one: restart tap tracking
				start_x_d = item.first_x;
				start_y_d = item.first_y;
				touch_start_d = item.now_ms;
				if (one_valid_q) begin
					tap_seen_d = 1'b0; drag_hold_d = 1'b0; left_held_d = 1'b0;
				end
			end else begin
				r0 = tgr_pkg::mk_res(tgr_pkg::EV_RELX,
					tgr_pkg::delta17(item.first_x, prev_fx_q), 1'b0);
				r1 = tgr_pkg::mk_res(tgr_pkg::EV_RELY,
					tgr_pkg::delta17(item.first_y, prev_fy_q), 1'b0);
				n  = 2'd2;
			end
			prev_fx_d = item.first_x; prev_fy_d = item.first_y;
			one_valid_d = 1'b1;
			two_valid_d = 1'b0;
		end else if (item.touches == 2'd2) begin
			if (!two_valid_q) begin
				touch_start_d = item.now_ms;
				tap_seen_d = 1'b0; drag_hold_d = 1'b0;
				if (left_held_q) begin
					left_held_d = 1'b0;
					r0 = tgr_pkg::mk_res(tgr_pkg::EV_LEFT, 17'sd0, 1'b0);
					n  = 2'd1;
				end
			end else begin
				if (ym != 17'sd0) begin
					r0 = tgr_pkg::mk_res(tgr_pkg::EV_WHEEL, -ym, 1'b0);
					n  = 2'd1;
				end
				if (xm != 17'sd0) begin
					if (n == 2'd0) begin
						r0 = tgr_pkg::mk_res(tgr_pkg::EV_HWHEEL, xm, 1'b0);
					end else begin
						r1 = tgr_pkg::mk_res(tgr_pkg::EV_HWHEEL, xm, 1'b0);
					end
					n = n + 2'd1;
				end
			end
			prev_fx_d = item.first_x; prev_fy_d = item.first_y;
			prev_sx_d = item.second_x; prev_sy_d = item.second_y;
			one_valid_d = 1'b1;
			two_valid_d = 1'b1;
		end else begin
			// lift
			if (two_valid_q) begin
				if (dur < {16'd0, cfg_q.tap_max_ms}) begin
					r0 = tgr_pkg::mk_res(tgr_pkg::EV_RIGHT, 17'sd1, 1'b1);
					n  = 2'd1;
					pending_d = tgr_pkg::PEND_RIGHT;
				end
			end else if (one_valid_q) begin
				if (is_tap) begin
					if ((gap < {16'd0, cfg_q.double_tap_ms}) && tap_seen_q) begin
						drag_hold_d = 1'b1;
						left_held_d = 1'b1;
						r0 = tgr_pkg::mk_res(tgr_pkg::EV_LEFT, 17'sd1, 1'b0);
						n  = 2'd1;
						tap_seen_d = 1'b0;
					end else begin
						if (!drag_hold_q) begin
							r0 = tgr_pkg::mk_res(tgr_pkg::EV_LEFT, 17'sd1, 1'b1);
							n  = 2'd1;
							pending_d = tgr_pkg::PEND_LEFT;
						end
						tap_seen_d = 1'b1;
					end
					last_tap_d = item.now_ms;
				end else begin
					if (drag_hold_q && left_held_q) begin
						drag_hold_d = 1'b0;
						left_held_d = 1'b0;
						r0 = tgr_pkg::mk_res(tgr_pkg::EV_LEFT, 17'sd0, 1'b0);
						n  = 2'd1;
					end
					// tap stamp unchanged here, so the gap above is current
					if (gap > {16'd0, cfg_q.tap_expire_ms}) begin
						tap_seen_d = 1'b0;
					end
				end
			end
			one_valid_d = 1'b0;
			two_valid_d = 1'b0;
		end

		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end

		push.n  = n;
		push.r0 = r0;
		push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_fx_q <= '0; prev_fy_q <= '0; prev_sx_q <= '0; prev_sy_q <= '0;
			start_x_q <= '0; start_y_q <= '0;
			touch_start_q <= '0; last_tap_q <= '0;
			one_valid_q <= 1'b0; two_valid_q <= 1'b0;
			tap_seen_q <= 1'b0; drag_hold_q <= 1'b0; left_held_q <= 1'b0;
			pending_q <= tgr_pkg::PEND_NONE;
		end else if (step) begin
			prev_fx_q <= prev_fx_d; prev_fy_q <= prev_fy_d;
			prev_sx_q <= prev_sx_d; prev_sy_q <= prev_sy_d;
			start_x_q <= start_x_d; start_y_q <= start_y_d;
			touch_start_q <= touch_start_d; last_tap_q <= last_tap_d;
			one_valid_q <= one_valid_d; two_valid_q <= two_valid_d;
			tap_seen_q <= tap_seen_d; drag_hold_q <= drag_hold_d; left_held_q <= left_held_d;
			pending_q <= pending_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/tgr_resq.sv */
// tgr_resq: four-entry result queue, takes up to two beats a cycle, sends one
// depends on tgr_pkg and tgr_out_if
`timescale 1ns / 1ps
`default_nettype none

module tgr_resq (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire tgr_pkg::push_t push,
	output logic         room,
	tgr_out_if.source    out
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	tgr_pkg::res_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop;
	tgr_pkg::res_t    head;

	assign pop  = out.valid && out.ready;
	// room for a full two-beat item regardless of this cycle's pop
	assign room = count_q <= (PTR_W+1)'(DEPTH - 2);
	assign head = mem_q[rptr_q];

	assign out.valid       = count_q != '0;
	assign out.event_kind  = head.event_kind;
	assign out.event_value = head.event_value;
	assign out.arm_release = head.arm_release;
	assign out.last        = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(push.n);
			rptr_q  <= rptr_q + PTR_W'(pop);
			count_q <= count_q + (PTR_W+1)'(push.n) - (PTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/touchpad_gesture_recognizer_unit.sv */
// path: an accepted item is registered and evaluated in the next cycle; its result beats
//   go into the result queue once it has room and leave from the queue head
// throughput: one item per cycle while the result queue has room; sustained rate is
//   bounded by the single result port, one beat per cycle
// reset: arst_n clears all gesture state, the queue and the input stage, and loads
//   the configuration registers with their defaults
`timescale 1ns / 1ps
`default_nettype none

module touchpad_gesture_recognizer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tgr_in_if.sink                             in,
	tgr_out_if.source                          out,
	input  wire logic                          cfg_we,
	input  wire logic [tgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tgr_pkg::CFG_W-1:0]     cfg_data
);

	// input stage register
	logic           valid_s1;
	tgr_pkg::item_t item_s1;

	logic           room;
	logic           advance;
	tgr_pkg::push_t core_push;
	tgr_pkg::push_t q_push;

	// the registered item moves on once the queue can hold its two beats;
	// a new item is taken in the same cycle the stage drains
	assign advance  = valid_s1 && room;
	assign in.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.valid && in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			item_s1.func     <= in.func;
			item_s1.touches  <= in.touches;
			item_s1.first_x  <= in.first_x;
			item_s1.first_y  <= in.first_y;
			item_s1.second_x <= in.second_x;
			item_s1.second_y <= in.second_y;
			item_s1.now_ms   <= in.now_ms;
		end
	end

	// gesture state and the result decision for the staged item
	tgr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (core_push)
	);

	// only a consumed item pushes its beats
	always_comb begin
		q_push   = core_push;
		q_push.n = advance ? core_push.n : 2'd0;
	end

	// result queue decouples the item side from a stalled result port
	tgr_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.room   (room),
		.out    (out)
	);

endmodule

`default_nettype wire
